@@ src/fss_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fss_pkg: shared types and constants for the fuzzy subsequence scorer
// Widths, scoring weights, register indexes and the case-fold helper.
// ----------------------------------------------------------------------------
package fss_pkg;

  localparam int PatternMax = 16;
  localparam int CharW      = 8;
  localparam int PosW       = 5;
  localparam int FirstW     = 4;
  localparam int RunW       = 5;
  localparam int ScoreW     = 17;
  localparam int GainW      = 9;
  localparam int DeltaW     = 11;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 64;
  localparam int InDataW    = 8;
  localparam int OutDataW   = 24;

  localparam int RunWeight   = 10;
  localparam int MissCost    = 10;
  localparam int OverrunCost = 1;
  localparam int RunMax      = 31;

  localparam logic [CharW-1:0] SpaceCode = 8'h20;
  localparam logic [CharW-1:0] UpperA    = 8'h41;
  localparam logic [CharW-1:0] UpperZ    = 8'h5A;
  localparam logic [CharW-1:0] CaseBit   = 8'h20;

  localparam logic [ScoreW-1:0] ScoreMax = {1'b0, {(ScoreW-1){1'b1}}};
  localparam logic [ScoreW-1:0] ScoreMin = {1'b1, {(ScoreW-1){1'b0}}};

  typedef enum logic [CfgIdxW-1:0] {
    CfgPatLow  = 2'd0,
    CfgPatHigh = 2'd1,
    CfgPatLen  = 2'd2
  } cfg_reg_e;

  typedef logic [PatternMax-1:0][CharW-1:0] pattern_t;

  typedef struct packed {
    logic [PosW-1:0]          pos;
    logic signed [ScoreW-1:0] score;
    logic [RunW-1:0]          run;
  } scan_state_t;

  function automatic logic [CharW-1:0] fold_case(input logic [CharW-1:0] c);
    logic [CharW-1:0] r;
    r = c;
    if (c >= UpperA && c <= UpperZ) begin
      r = c | CaseBit;
    end
    return r;
  endfunction

endpackage

@@ src/fss_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fss_step: per-character scoring update
// Finds the next live pattern byte, compares it to the candidate byte and
// forms the next position, run length and saturated score.
// ----------------------------------------------------------------------------
module fss_step (
  input  fss_pkg::scan_state_t                 state_i,
  input  fss_pkg::pattern_t                    pattern_i,
  input  logic [fss_pkg::PosW-1:0]             pat_len_i,
  input  logic [fss_pkg::CharW-1:0]            char_i,
  output fss_pkg::scan_state_t                 state_o,
  output logic                                 done_o
);
  import fss_pkg::*;

  logic [PosW-1:0]         len_eff;
  logic [PatternMax-1:0]   live;
  logic [PatternMax-1:0]   cand;
  logic [PatternMax-1:0]   later;
  logic [FirstW-1:0]       first;
  logic                    found;
  logic [CharW-1:0]        pat_char;
  logic                    is_space;
  logic                    hit;
  logic                    case_diff;
  logic [GainW-1:0]        run_gain;
  logic [DeltaW-1:0]       delta;
  logic [ScoreW:0]         sum;

  assign len_eff = (pat_len_i > PosW'(PatternMax)) ? PosW'(PatternMax) : pat_len_i;

  always_comb begin
    first = '0;
    for (int i = 0; i < PatternMax; i++) begin
      live[i] = (PosW'(i) < len_eff) && (pattern_i[i] != SpaceCode);
      cand[i] = live[i] && (PosW'(i) >= state_i.pos);
    end
    for (int i = PatternMax - 1; i >= 0; i--) begin
      if (cand[i]) begin
        first = FirstW'(i);
      end
    end
    for (int i = 0; i < PatternMax; i++) begin
      later[i] = live[i] && (FirstW'(i) > first);
    end
  end

  assign found     = |cand;
  assign pat_char  = pattern_i[first];
  assign is_space  = (char_i == SpaceCode);
  assign hit       = (fold_case(char_i) == fold_case(pat_char));
  assign case_diff = (char_i != pat_char);
  assign run_gain  = GainW'(state_i.run) * GainW'(RunWeight);

  always_comb begin
    state_o = state_i;
    done_o  = 1'b1;
    delta   = '0;
    if (!found) begin
      delta = DeltaW'(-OverrunCost);
    end else if (is_space) begin
      state_o.pos = {1'b0, first};
      done_o      = 1'b0;
    end else if (hit) begin
      delta       = {2'b00, run_gain} - {{(DeltaW-1){1'b0}}, case_diff};
      state_o.pos = {1'b0, first} + PosW'(1);
      if (state_i.run < RunW'(RunMax)) begin
        state_o.run = state_i.run + RunW'(1);
      end
      done_o = ~|later;
    end else begin
      delta       = DeltaW'(-MissCost);
      state_o.pos = {1'b0, first};
      state_o.run = '0;
      done_o      = 1'b0;
    end
    sum = {state_i.score[ScoreW-1], state_i.score}
        + {{(ScoreW+1-DeltaW){delta[DeltaW-1]}}, delta};
    if (sum[ScoreW] == sum[ScoreW-1]) begin
      state_o.score = sum[ScoreW-1:0];
    end else if (sum[ScoreW]) begin
      state_o.score = ScoreMin;
    end else begin
      state_o.score = ScoreMax;
    end
  end

endmodule

@@ src/fuzzy_subsequence_scorer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fuzzy_subsequence_scorer: streaming fuzzy subsequence match scorer
// Scores a candidate string, one byte per transfer, against a configured
// pattern of up to sixteen bytes with case-insensitive matching.
//
// Usage:
//   Write the pattern bytes and length over the cfg channel while idle
//   (index 0: bytes 0-7, index 1: bytes 8-15, index 2: length).
//   Send candidate bytes on s_axis, tdata = char_code, tlast marking the
//   final byte. One result per candidate leaves on m_axis after the tlast
//   byte: tuser = matched, tdata = score (zero unless matched).
//   Throughput: one byte per cycle except while a tlast byte waits; the scan
//   state updates through the fss_step logic between the input and result
//   registers; a tlast byte fills the input, then the result register.
//   A stalled m_axis holds the result; bytes that cause no result keep
//   flowing, and a second tlast byte waits in the input register until
//   the pending result is taken.
//   Reset clears the pattern registers, scan state and both valid flags.
// ----------------------------------------------------------------------------
module fuzzy_subsequence_scorer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [fss_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [fss_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [fss_pkg::InDataW-1:0]       s_axis_tdata,   // [7:0] char_code
  input  logic                              s_axis_tlast,   // last_char
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [fss_pkg::OutDataW-1:0]      m_axis_tdata,   // [16:0] score, rest zero
  output logic                              m_axis_tuser    // [0] matched
);
  import fss_pkg::*;

  logic [CfgDataW-1:0] pat_low_q;
  logic [CfgDataW-1:0] pat_high_q;
  logic [PosW-1:0]     pat_len_q;
  pattern_t            pattern;

  logic                in_valid_q;
  logic [CharW-1:0]    in_char_q;
  logic                in_last_q;

  scan_state_t         state_q;
  scan_state_t         state_d;
  scan_state_t         step_state;
  logic                step_done;

  logic                out_valid_q;
  logic                out_matched_q;
  logic [ScoreW-1:0]   out_score_q;

  logic                out_free;
  logic                fire;
  logic                cfg_fire;
  logic                in_fire;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign pattern     = {pat_high_q, pat_low_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= '0;
    end else if (cfg_fire) begin
      case (cfg_index_i)
        CfgPatLow:  pat_low_q  <= cfg_data_i;
        CfgPatHigh: pat_high_q <= cfg_data_i;
        CfgPatLen:  pat_len_q  <= cfg_data_i[PosW-1:0];
        default:    ;
      endcase
    end
  end

  assign out_free      = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready = !in_valid_q || fire;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_char_q <= s_axis_tdata[CharW-1:0];
      in_last_q <= s_axis_tlast;
    end
  end

  fss_step u_step (
    .state_i   (state_q),
    .pattern_i (pattern),
    .pat_len_i (pat_len_q),
    .char_i    (in_char_q),
    .state_o   (step_state),
    .done_o    (step_done)
  );

  always_comb begin
    state_d = state_q;
    if (fire) begin
      state_d = in_last_q ? '0 : step_state;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && in_last_q) begin
      out_matched_q <= step_done;
      out_score_q   <= step_done ? step_state.score : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_matched_q;
  assign m_axis_tdata  = {{(OutDataW-ScoreW){1'b0}}, out_score_q};

endmodule
